// ----- rtl/gcd_pkg.sv -----
// Shared widths, constants, word tags and helpers for the great-circle distance core.
package gcd_pkg;

    localparam int MIN_W      = 16;
    localparam int ANG_W      = 36;
    localparam int Z_W        = 34;
    localparam int XY_W       = 34;
    localparam int Q_W        = 34;
    localparam int Q_FRAC     = 30;
    localparam int SQ_IN_W    = 31;
    localparam int SQ_N_W     = 64;
    localparam int SQRT_STEPS = 32;
    localparam int OUT_W      = 16;
    localparam int RND_SHIFT  = 16;
    localparam int SC_LANES   = 4;
    localparam int SQ_LANES   = 2;
    localparam int MAX_STAGES = 24;

    localparam logic [0:0] REG_USE_HAV = 1'b0;

    localparam logic signed [ANG_W-1:0] RAD_PER_MIN = 36'sd312339;
    localparam logic signed [ANG_W-1:0] Q_ONE       = 36'sd1073741824;
    localparam logic signed [ANG_W-1:0] Q_HALF_PI   = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q_PI        = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q_TWO_PI    = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] RND_HALF    = 36'sd32768;
    localparam logic signed [Q_W-1:0]   QW_ONE      = 34'sd1073741824;
    localparam logic signed [XY_W-1:0]  INV_GAIN    = 34'sd652032874;
    localparam logic [OUT_W-1:0]        OUT_MAX     = 16'd51472;

    localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
    };

    typedef struct packed {
        logic                  hav;
        logic signed [Q_W-1:0] v;
    } sq_tag_t;

    typedef struct packed {
        logic hav;
        logic fold;
        logic zero;
    } vec_tag_t;

    function automatic logic signed [MIN_W-1:0] minutes(input logic signed [9:0] deg,
                                                       input logic signed [6:0] mn);
        return MIN_W'(deg) * MIN_W'(60) + MIN_W'(mn);
    endfunction

    // Q30 product, truncated toward zero
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
        logic               neg;
        logic [Q_W-1:0]     ua;
        logic [Q_W-1:0]     ub;
        logic [2*Q_W-1:0]   p;
        logic [Q_W-1:0]     pt;
        neg = a[Q_W-1] ^ b[Q_W-1];
        ua  = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
        ub  = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
        p   = ua * ub;
        pt  = p[Q_FRAC +: Q_W];
        return neg ? Q_W'(-pt) : pt;
    endfunction

endpackage

// ----- rtl/gcd_prep.sv -----
// Angle formation in Q30 radians and range reduction to +-pi/2 for four sine/cosine lanes.
module gcd_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              in_hav,
    input  logic signed [7:0]                 lat1_deg,
    input  logic signed [6:0]                 lat1_min,
    input  logic signed [8:0]                 lon1_deg,
    input  logic signed [6:0]                 lon1_min,
    input  logic signed [7:0]                 lat2_deg,
    input  logic signed [6:0]                 lat2_min,
    input  logic signed [8:0]                 lon2_deg,
    input  logic signed [6:0]                 lon2_min,
    output logic                              out_valid,
    output logic                              out_hav,
    output logic signed [gcd_pkg::Z_W-1:0]    out_z [gcd_pkg::SC_LANES],
    output logic [gcd_pkg::SC_LANES-1:0]      out_neg
);
    import gcd_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                    h1_reg, h2_reg, h3_reg, h4_reg, h5_reg, h6_reg;
    logic signed [MIN_W-1:0] m1_reg [4];
    logic signed [ANG_W-1:0] a2_reg [4];
    logic signed [ANG_W-1:0] a3_reg [SC_LANES];
    logic signed [ANG_W-1:0] a4_reg [SC_LANES];
    logic signed [ANG_W-1:0] a5_reg [SC_LANES];
    logic signed [Z_W-1:0]   z6_reg [SC_LANES];
    logic [SC_LANES-1:0]     n6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg <= in_hav;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
            h4_reg <= h3_reg;
            h5_reg <= h4_reg;
            h6_reg <= h5_reg;
            m1_reg[0] <= minutes(10'(lat1_deg), lat1_min);
            m1_reg[1] <= minutes(10'(lon1_deg), lon1_min);
            m1_reg[2] <= minutes(10'(lat2_deg), lat2_min);
            m1_reg[3] <= minutes(10'(lon2_deg), lon2_min);
            for (int i = 0; i < 4; i++) begin
                a2_reg[i] <= ANG_W'(m1_reg[i]) * RAD_PER_MIN;
            end
            a3_reg[0] <= a2_reg[0];
            a3_reg[1] <= a2_reg[2];
            if (h2_reg) begin
                a3_reg[2] <= (a2_reg[2] - a2_reg[0]) >>> 1;
                a3_reg[3] <= (a2_reg[3] - a2_reg[1]) >>> 1;
            end else begin
                a3_reg[2] <= a2_reg[1] - a2_reg[3];
                a3_reg[3] <= '0;
            end
            for (int l = 0; l < SC_LANES; l++) begin
                if (a3_reg[l] >= Q_TWO_PI) begin
                    a4_reg[l] <= a3_reg[l] - Q_TWO_PI;
                end else if (a3_reg[l] <= -Q_TWO_PI) begin
                    a4_reg[l] <= a3_reg[l] + Q_TWO_PI;
                end else begin
                    a4_reg[l] <= a3_reg[l];
                end
                if (a4_reg[l] > Q_PI) begin
                    a5_reg[l] <= a4_reg[l] - Q_TWO_PI;
                end else if (a4_reg[l] < -Q_PI) begin
                    a5_reg[l] <= a4_reg[l] + Q_TWO_PI;
                end else begin
                    a5_reg[l] <= a4_reg[l];
                end
                if (a5_reg[l] > Q_HALF_PI) begin
                    z6_reg[l] <= Z_W'(a5_reg[l] - Q_PI);
                    n6_reg[l] <= 1'b1;
                end else if (a5_reg[l] < -Q_HALF_PI) begin
                    z6_reg[l] <= Z_W'(a5_reg[l] + Q_PI);
                    n6_reg[l] <= 1'b1;
                end else begin
                    z6_reg[l] <= Z_W'(a5_reg[l]);
                    n6_reg[l] <= 1'b0;
                end
            end
        end
    end

    assign out_valid = v6_reg;
    assign out_hav   = h6_reg;
    assign out_z     = z6_reg;
    assign out_neg   = n6_reg;

endmodule

// ----- rtl/gcd_sincos.sv -----
// Pipelined rotation CORDIC giving sine and cosine on four lanes.
module gcd_sincos #(
    parameter int STAGES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              in_hav,
    input  logic signed [gcd_pkg::Z_W-1:0]    in_z [gcd_pkg::SC_LANES],
    input  logic [gcd_pkg::SC_LANES-1:0]      in_neg,
    output logic                              out_valid,
    output logic                              out_hav,
    output logic signed [gcd_pkg::XY_W-1:0]   out_s [gcd_pkg::SC_LANES],
    output logic signed [gcd_pkg::XY_W-1:0]   out_c [gcd_pkg::SC_LANES]
);
    import gcd_pkg::*;

    logic signed [XY_W-1:0] x_reg [STAGES+1][SC_LANES];
    logic signed [XY_W-1:0] y_reg [STAGES+1][SC_LANES];
    logic signed [Z_W-1:0]  z_reg [STAGES+1][SC_LANES];
    logic [SC_LANES-1:0]    neg_reg [STAGES+1];
    logic                   hav_reg [STAGES+1];
    logic                   vld_reg [STAGES+1];
    logic signed [XY_W-1:0] s_reg [SC_LANES];
    logic signed [XY_W-1:0] c_reg [SC_LANES];
    logic                   hav_out_reg;
    logic                   vld_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < STAGES; i++) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            vld_out_reg <= vld_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < SC_LANES; l++) begin
                x_reg[0][l] <= INV_GAIN;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= in_z[l];
            end
            neg_reg[0] <= in_neg;
            hav_reg[0] <= in_hav;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < SC_LANES; l++) begin
                    if (z_reg[i][l] >= 0) begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - ATAN_TAB[i];
                    end else begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + ATAN_TAB[i];
                    end
                end
                neg_reg[i+1] <= neg_reg[i];
                hav_reg[i+1] <= hav_reg[i];
            end
        end
    end

    // half-turn fold flips both results
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < SC_LANES; l++) begin
                s_reg[l] <= neg_reg[STAGES][l] ? -y_reg[STAGES][l] : y_reg[STAGES][l];
                c_reg[l] <= neg_reg[STAGES][l] ? -x_reg[STAGES][l] : x_reg[STAGES][l];
            end
            hav_out_reg <= hav_reg[STAGES];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_hav   = hav_out_reg;
    assign out_s     = s_reg;
    assign out_c     = c_reg;

endmodule

// ----- rtl/gcd_sqrt.sv -----
// Pipelined bit-by-bit square root, one result bit per stage, on two lanes.
module gcd_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  gcd_pkg::sq_tag_t                  in_tag,
    input  logic [gcd_pkg::SQ_IN_W-1:0]       in_v [gcd_pkg::SQ_LANES],
    output logic                              out_valid,
    output gcd_pkg::sq_tag_t                  out_tag,
    output logic [gcd_pkg::SQ_IN_W-1:0]       out_r [gcd_pkg::SQ_LANES]
);
    import gcd_pkg::*;

    logic [SQ_N_W-1:0] n_reg [SQRT_STEPS+1][SQ_LANES];
    logic [SQ_N_W-1:0] r_reg [SQRT_STEPS+1][SQ_LANES];
    sq_tag_t           tag_reg [SQRT_STEPS+1];
    logic              vld_reg [SQRT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < SQ_LANES; l++) begin
                n_reg[0][l] <= SQ_N_W'(in_v[l]) << Q_FRAC;
                r_reg[0][l] <= '0;
            end
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQ_N_W-1:0] BIT = SQ_N_W'(1) << (SQ_N_W - 2 - 2 * k);
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < SQ_LANES; l++) begin
                    if (n_reg[k][l] >= r_reg[k][l] + BIT) begin
                        n_reg[k+1][l] <= n_reg[k][l] - (r_reg[k][l] + BIT);
                        r_reg[k+1][l] <= (r_reg[k][l] >> 1) + BIT;
                    end else begin
                        n_reg[k+1][l] <= n_reg[k][l];
                        r_reg[k+1][l] <= r_reg[k][l] >> 1;
                    end
                end
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < SQ_LANES; l++) begin
            out_r[l] = r_reg[SQRT_STEPS][l][SQ_IN_W-1:0];
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign out_tag   = tag_reg[SQRT_STEPS];

endmodule

// ----- rtl/gcd_vec.sv -----
// Pipelined vectoring CORDIC giving atan2 for a non-negative x.
module gcd_vec #(
    parameter int STAGES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  gcd_pkg::vec_tag_t                 in_tag,
    input  logic signed [gcd_pkg::XY_W-1:0]   in_x,
    input  logic signed [gcd_pkg::XY_W-1:0]   in_y,
    output logic                              out_valid,
    output gcd_pkg::vec_tag_t                 out_tag,
    output logic signed [gcd_pkg::Z_W-1:0]    out_z
);
    import gcd_pkg::*;

    logic signed [XY_W-1:0] x_reg [STAGES+1];
    logic signed [XY_W-1:0] y_reg [STAGES+1];
    logic signed [Z_W-1:0]  z_reg [STAGES+1];
    vec_tag_t               tag_reg [STAGES+1];
    logic                   vld_reg [STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < STAGES; i++) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= in_x;
            y_reg[0]   <= in_y;
            z_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];
    assign out_z     = z_reg[STAGES];

endmodule

// ----- rtl/great_circle_distance_core.sv -----
// Great-circle distance core: top level with products, mode register and output skid stage.
// Takes one point pair per cycle while s_ready is high and returns the central angle in
// radians times 16384, rounded and clamped to 0..pi, in input order. Its stages, in order,
// are angle formation and reduction, the sine/cosine CORDIC, Q30 products and clamping, a
// 32-step square-root pipeline, the atan2 CORDIC, and rounding and output. The whole
// pipeline advances together and holds only when both the output word and the skid word
// wait to be taken.
// The mode bit (byte address 0, bit 0, reset 1) selects the haversine form; clear it for
// the spherical law of cosines. Write it only while no word is in flight.
module great_circle_distance_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [7:0]                 s_lat1_deg,
    input  logic signed [6:0]                 s_lat1_min,
    input  logic signed [8:0]                 s_lon1_deg,
    input  logic signed [6:0]                 s_lon1_min,
    input  logic signed [7:0]                 s_lat2_deg,
    input  logic signed [6:0]                 s_lat2_min,
    input  logic signed [8:0]                 s_lon2_deg,
    input  logic signed [6:0]                 s_lon2_min,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gcd_pkg::OUT_W-1:0]         m_central_angle
);
    import gcd_pkg::*;

    logic                   en;
    logic                   hav_reg;

    logic                   pr_valid, pr_hav;
    logic signed [Z_W-1:0]  pr_z [SC_LANES];
    logic [SC_LANES-1:0]    pr_neg;

    logic                   sc_valid, sc_hav;
    logic signed [XY_W-1:0] sc_s [SC_LANES];
    logic signed [XY_W-1:0] sc_c [SC_LANES];

    logic                   k1_vld_reg, k2_vld_reg, k3_vld_reg, k4_vld_reg, k5_vld_reg;
    logic                   k6_vld_reg, k7_vld_reg, k8_vld_reg;
    logic                   k1_hav_reg, k2_hav_reg, k3_hav_reg, k4_hav_reg, k5_hav_reg;
    logic signed [Q_W-1:0]  k1_m1_reg, k1_m2_reg, k1_m3_reg;
    logic signed [Q_W-1:0]  k2_m1_reg, k2_m4_reg;
    logic signed [Q_W:0]    v_sum;
    logic signed [Q_W-1:0]  v_next;
    logic signed [Q_W-1:0]  k3_v_reg;
    logic signed [Q_W-1:0]  k4_v_reg, k4_w_reg;
    logic [SQ_IN_W-1:0]     k5_sq_reg [SQ_LANES];
    sq_tag_t                k5_tag_reg;

    logic                   sq_valid;
    sq_tag_t                sq_tag;
    logic [SQ_IN_W-1:0]     sq_r [SQ_LANES];

    logic signed [XY_W-1:0] x_sel;
    logic signed [XY_W-1:0] k6_x_reg, k6_y_reg;
    vec_tag_t               k6_tag_reg;

    logic                   vc_valid;
    vec_tag_t               vc_tag;
    logic signed [Z_W-1:0]  vc_z;

    logic signed [ANG_W-1:0] zf_next;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [ANG_W-1:0] k7_ang_reg;
    logic [ANG_W-1:0]        rnd_sum;
    logic [ANG_W-RND_SHIFT-1:0] rnd_q;
    logic [OUT_W-1:0]        res_next;
    logic [OUT_W-1:0]        k8_res_reg;

    logic [OUT_W-1:0]       out_reg, skid_reg;
    logic                   out_vld_reg, skid_vld_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_USE_HAV) ? {31'b0, hav_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hav_reg <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2:2] == REG_USE_HAV) begin
            hav_reg <= pwdata[0];
        end
    end

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    gcd_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_hav    (hav_reg),
        .lat1_deg  (s_lat1_deg),
        .lat1_min  (s_lat1_min),
        .lon1_deg  (s_lon1_deg),
        .lon1_min  (s_lon1_min),
        .lat2_deg  (s_lat2_deg),
        .lat2_min  (s_lat2_min),
        .lon2_deg  (s_lon2_deg),
        .lon2_min  (s_lon2_min),
        .out_valid (pr_valid),
        .out_hav   (pr_hav),
        .out_z     (pr_z),
        .out_neg   (pr_neg)
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pr_valid),
        .in_hav    (pr_hav),
        .in_z      (pr_z),
        .in_neg    (pr_neg),
        .out_valid (sc_valid),
        .out_hav   (sc_hav),
        .out_s     (sc_s),
        .out_c     (sc_c)
    );

    // lanes: 0 lat1, 1 lat2, 2 half dlat or dlon, 3 half dlon or zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_vld_reg <= 1'b0;
            k2_vld_reg <= 1'b0;
            k3_vld_reg <= 1'b0;
            k4_vld_reg <= 1'b0;
            k5_vld_reg <= 1'b0;
            k6_vld_reg <= 1'b0;
            k7_vld_reg <= 1'b0;
            k8_vld_reg <= 1'b0;
        end else if (en) begin
            k1_vld_reg <= sc_valid;
            k2_vld_reg <= k1_vld_reg;
            k3_vld_reg <= k2_vld_reg;
            k4_vld_reg <= k3_vld_reg;
            k5_vld_reg <= k4_vld_reg;
            k6_vld_reg <= sq_valid;
            k7_vld_reg <= vc_valid;
            k8_vld_reg <= k7_vld_reg;
        end
    end

    always_comb begin
        v_sum = (Q_W+1)'(k2_m1_reg) + (Q_W+1)'(k2_m4_reg);
        if (v_sum > Q_ONE) begin
            v_next = QW_ONE;
        end else if (k2_hav_reg && v_sum < 0) begin
            v_next = '0;
        end else if (v_sum < -Q_ONE) begin
            v_next = -QW_ONE;
        end else begin
            v_next = Q_W'(v_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_hav_reg <= sc_hav;
            if (sc_hav) begin
                k1_m1_reg <= qmul(Q_W'(sc_s[2]), Q_W'(sc_s[2]));
                k1_m3_reg <= qmul(Q_W'(sc_s[3]), Q_W'(sc_s[3]));
            end else begin
                k1_m1_reg <= qmul(Q_W'(sc_s[0]), Q_W'(sc_s[1]));
                k1_m3_reg <= Q_W'(sc_c[2]);
            end
            k1_m2_reg  <= qmul(Q_W'(sc_c[0]), Q_W'(sc_c[1]));

            k2_hav_reg <= k1_hav_reg;
            k2_m1_reg  <= k1_m1_reg;
            k2_m4_reg  <= qmul(k1_m2_reg, k1_m3_reg);

            k3_hav_reg <= k2_hav_reg;
            k3_v_reg   <= v_next;

            k4_hav_reg <= k3_hav_reg;
            k4_v_reg   <= k3_v_reg;
            k4_w_reg   <= qmul(k3_v_reg, k3_v_reg);

            k5_hav_reg   <= k4_hav_reg;
            k5_sq_reg[0] <= k4_hav_reg ? SQ_IN_W'(k4_v_reg) : SQ_IN_W'(QW_ONE - k4_w_reg);
            k5_sq_reg[1] <= SQ_IN_W'(QW_ONE - k4_v_reg);
            k5_tag_reg   <= '{hav: k4_hav_reg, v: k4_v_reg};
        end
    end

    gcd_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (k5_vld_reg),
        .in_tag    (k5_tag_reg),
        .in_v      (k5_sq_reg),
        .out_valid (sq_valid),
        .out_tag   (sq_tag),
        .out_r     (sq_r)
    );

    assign x_sel = sq_tag.hav ? XY_W'(sq_r[1]) : XY_W'(sq_tag.v);

    always_ff @(posedge aclk) begin
        if (en) begin
            k6_y_reg        <= XY_W'(sq_r[0]);
            k6_x_reg        <= (x_sel < 0) ? -x_sel : x_sel;
            k6_tag_reg.hav  <= sq_tag.hav;
            k6_tag_reg.fold <= x_sel < 0;
            k6_tag_reg.zero <= (sq_r[0] == '0) && (x_sel == '0);
        end
    end

    gcd_vec #(.STAGES(CORDIC_STAGES)) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (k6_vld_reg),
        .in_tag    (k6_tag_reg),
        .in_x      (k6_x_reg),
        .in_y      (k6_y_reg),
        .out_valid (vc_valid),
        .out_tag   (vc_tag),
        .out_z     (vc_z)
    );

    always_comb begin
        zf_next = ANG_W'(vc_z);
        if (vc_tag.fold) begin
            zf_next = Q_PI - zf_next;
        end
        if (vc_tag.zero) begin
            zf_next = '0;
        end
        ang_next = vc_tag.hav ? (zf_next <<< 1) : zf_next;
        if (ang_next < 0) begin
            ang_next = '0;
        end
        rnd_sum  = ANG_W'(k7_ang_reg + RND_HALF);
        rnd_q    = rnd_sum[ANG_W-1:RND_SHIFT];
        res_next = (rnd_q > (ANG_W-RND_SHIFT)'(OUT_MAX)) ? OUT_MAX : rnd_q[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k7_ang_reg <= ang_next;
            k8_res_reg <= res_next;
        end
    end

    // output word plus skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= k8_vld_reg;
            end
        end else if (en && k8_vld_reg) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : k8_res_reg;
        end else if (en && k8_vld_reg) begin
            skid_reg <= k8_res_reg;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_central_angle = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held without an output word");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_ready && k8_vld_reg))
        else $error("skid word filled without a stalled output");

    a_out_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_reg <= OUT_MAX))
        else $error("central angle beyond pi");

endmodule

// ----- test/tb_great_circle_distance_core.sv -----
// Testbench for great_circle_distance_core: point pairs checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_great_circle_distance_core;
    import gcd_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = 2 * STAGES + 51;
    localparam logic [2:0] ADDR_USE_HAV = 3'(4 * REG_USE_HAV);
    localparam longint GC_ONE = 64'sd1 << 30;
    localparam longint GC_PI = 64'sd3373259426;
    localparam longint GC_HALF_PI = 64'sd1686629713;
    localparam longint GC_TWO_PI = 64'sd6746518852;
    localparam longint GC_GAIN = 64'sd652032874;

    typedef struct {
        int lat1_deg, lat1_min, lon1_deg, lon1_min;
        int lat2_deg, lat2_min, lon2_deg, lon2_min;
    } pair_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic signed [7:0] s_lat1_deg, s_lat2_deg;
    logic signed [8:0] s_lon1_deg, s_lon2_deg;
    logic signed [6:0] s_lat1_min, s_lon1_min, s_lat2_min, s_lon2_min;
    logic m_valid, m_ready;
    logic [OUT_W-1:0] m_central_angle;

    logic hav_mode;
    logic [15:0] angle_q[$];
    int mismatches;
    bit quiet;
    bit hold_req;

    great_circle_distance_core #(.CORDIC_STAGES(STAGES)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb_great_circle_distance_core: errors");
        $finish;
    end

    function automatic longint gc_asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint gc_mul(longint a, longint b);
        longint unsigned ua, ub;
        longint p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = longint'((ua * ub) >> 30);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint gc_sqrt(longint v);
        longint unsigned n, r, b;
        if (v <= 0) return 0;
        if (v > GC_ONE) v = GC_ONE;
        n = longint'(v) << 30;
        r = 0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void gc_sincos(longint a, output longint s, output longint c);
        longint x, y, z, t;
        bit neg;
        x = GC_GAIN;
        y = 0;
        neg = 0;
        z = a % GC_TWO_PI;
        if (z > GC_PI) z -= GC_TWO_PI;
        else if (z < -GC_PI) z += GC_TWO_PI;
        if (z > GC_HALF_PI) begin
            z -= GC_PI;
            neg = 1;
        end else if (z < -GC_HALF_PI) begin
            z += GC_PI;
            neg = 1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - gc_asr(y, i);
                y = y + gc_asr(t, i);
                z -= longint'(ATAN_TAB[i]);
            end else begin
                x = x + gc_asr(y, i);
                y = y - gc_asr(t, i);
                z += longint'(ATAN_TAB[i]);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic longint gc_atan2(longint y, longint x);
        longint z, t;
        bit fold;
        z = 0;
        fold = 0;
        if (y == 0 && x == 0) return 0;
        if (x < 0) begin
            x = -x;
            fold = 1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + gc_asr(y, i);
                y = y - gc_asr(t, i);
                z += longint'(ATAN_TAB[i]);
            end else begin
                x = x - gc_asr(y, i);
                y = y + gc_asr(t, i);
                z -= longint'(ATAN_TAB[i]);
            end
        end
        return fold ? GC_PI - z : z;
    endfunction

    function automatic longint gc_rad(int deg, int mn);
        return (longint'(deg) * 60 + mn) * 312339;
    endfunction

    function automatic logic [15:0] central_angle_of(logic signed [7:0] la1d,
            logic signed [6:0] la1m, logic signed [8:0] lo1d, logic signed [6:0] lo1m,
            logic signed [7:0] la2d, logic signed [6:0] la2m, logic signed [8:0] lo2d,
            logic signed [6:0] lo2m, logic hav);
        longint lat1, lon1, lat2, lon2, s1, c1, s2, c2, sa, ca, sb, cb, v, ang;
        longint unsigned r;
        lat1 = gc_rad(la1d, la1m);
        lon1 = gc_rad(lo1d, lo1m);
        lat2 = gc_rad(la2d, la2m);
        lon2 = gc_rad(lo2d, lo2m);
        gc_sincos(lat1, s1, c1);
        gc_sincos(lat2, s2, c2);
        if (hav) begin
            gc_sincos(gc_asr(lat2 - lat1, 1), sa, ca);
            gc_sincos(gc_asr(lon2 - lon1, 1), sb, cb);
            v = gc_mul(sa, sa) + gc_mul(gc_mul(c1, c2), gc_mul(sb, sb));
            if (v < 0) v = 0;
            if (v > GC_ONE) v = GC_ONE;
            ang = 2 * gc_atan2(gc_sqrt(v), gc_sqrt(GC_ONE - v));
        end else begin
            gc_sincos(lon1 - lon2, sb, cb);
            v = gc_mul(s1, s2) + gc_mul(gc_mul(c1, c2), cb);
            if (v < -GC_ONE) v = -GC_ONE;
            if (v > GC_ONE) v = GC_ONE;
            ang = gc_atan2(gc_sqrt(GC_ONE - gc_mul(v, v)), v);
        end
        if (ang < 0) ang = 0;
        r = (longint'(ang) + 32768) >> 16;
        if (r > 64'(OUT_MAX)) r = 64'(OUT_MAX);
        return r[15:0];
    endfunction

    // expectation on input acceptance, comparison on output acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            angle_q.push_back(central_angle_of(s_lat1_deg, s_lat1_min, s_lon1_deg,
                s_lon1_min, s_lat2_deg, s_lat2_min, s_lon2_deg, s_lon2_min, hav_mode));
        if (aresetn && m_valid && m_ready) begin
            if (angle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %0d", m_central_angle);
            end else begin
                logic [15:0] want;
                want = angle_q.pop_front();
                if (want !== m_central_angle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("central_angle: expected %0d, got %0d", want,
                                 m_central_angle);
                end
            end
        end
    end

    // receiver
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (hold_req) begin
                hold_req = 0;
                stall = 400;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send(pair_t p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lat1_deg <= 8'(p.lat1_deg); s_lat1_min <= 7'(p.lat1_min);
        s_lon1_deg <= 9'(p.lon1_deg); s_lon1_min <= 7'(p.lon1_min);
        s_lat2_deg <= 8'(p.lat2_deg); s_lat2_min <= 7'(p.lat2_min);
        s_lon2_deg <= 9'(p.lon2_deg); s_lon2_min <= 7'(p.lon2_min);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_mode(logic m);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_USE_HAV; pwdata <= {31'd0, m};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        hav_mode = m;
        psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[0] !== m) begin
            mismatches++;
            if (mismatches <= 10) $display("mode bit read %0b, expected %0b", prdata[0], m);
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void coord(int span, output int deg, output int mn);
        deg = $urandom_range(0, 2 * span) - span;
        mn = (deg == span || deg == -span) ? 0 : $urandom_range(0, 59);
        if (deg < 0 || (deg == 0 && $urandom_range(0, 1))) mn = -mn;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        if ($urandom_range(0, 9) == 0) begin
            // full field widths, out-of-range included
            p.lat1_deg = $signed(8'($urandom)); p.lat1_min = $signed(7'($urandom));
            p.lon1_deg = $signed(9'($urandom)); p.lon1_min = $signed(7'($urandom));
            p.lat2_deg = $signed(8'($urandom)); p.lat2_min = $signed(7'($urandom));
            p.lon2_deg = $signed(9'($urandom)); p.lon2_min = $signed(7'($urandom));
        end else begin
            coord(90, p.lat1_deg, p.lat1_min);
            coord(180, p.lon1_deg, p.lon1_min);
            coord(90, p.lat2_deg, p.lat2_min);
            coord(180, p.lon2_deg, p.lon2_min);
            if ($urandom_range(0, 7) == 0) begin
                // near-identical or near-antipodal pairs
                p.lat2_deg = $urandom_range(0, 1) ? p.lat1_deg : -p.lat1_deg;
                p.lon2_deg = p.lon1_deg + ($urandom_range(0, 1) ? 0 : 180);
                if (p.lon2_deg > 180) p.lon2_deg -= 360;
            end
        end
        return p;
    endfunction

    // directed table: every row checked against the predictor
    pair_t directed[] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{45, 30, 120, 15, 45, 30, 120, 15},
        '{0, 0, 0, 0, 0, 0, 180, 0},
        '{90, 0, 0, 0, -90, 0, 0, 0},
        '{90, 0, 180, 0, 90, 0, -180, 0},
        '{-90, 0, -180, 0, 90, 0, 180, 0},
        '{89, 59, 179, 59, -89, -59, -179, -59},
        '{0, 0, 0, 0, 0, 0, 179, 59},
        '{0, 0, 0, 1, 0, 0, 0, 0},
        '{10, -20, 30, -40, -10, 20, -30, 40},
        '{127, 63, 255, 63, -128, -64, -256, -64},
        '{-128, -64, -256, -64, 127, 63, 255, 63},
        '{0, 0, 0, 0, 0, 0, 0, 1},
        '{51, 30, 0, -7, 40, 42, -74, 0},
        '{-33, -52, 151, 12, 51, 30, 0, -7},
        '{0, 0, 90, 0, 0, 0, -90, 0},
        '{45, 0, 0, 0, -45, 0, 180, 0},
        '{1, 0, 1, 0, 1, 0, 1, 0},
        '{0, 0, 0, 0, 0, 0, 360, 0}
    };

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0;
        s_lat1_deg = '0; s_lat1_min = '0; s_lon1_deg = '0; s_lon1_min = '0;
        s_lat2_deg = '0; s_lat2_min = '0; s_lon2_deg = '0; s_lon2_min = '0;
        hav_mode = 1'b1;
        mismatches = 0;
        quiet = 0;
        hold_req = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send(directed[i]);
        for (int n = 0; n < 280; n++) begin
            quiet = (n >= 100 && n < 160);
            send(random_pair());
        end
        quiet = 0;
        drain();

        write_mode(1'b0);
        foreach (directed[i]) send(directed[i]);
        for (int n = 0; n < 300; n++) begin
            quiet = (n >= 50 && n < 200);
            if (n == 60) hold_req = 1;
            send(random_pair());
        end
        quiet = 0;
        drain();

        write_mode(1'b1);
        for (int n = 0; n < 280; n++) send(random_pair());
        drain();

        if (mismatches == 0 && angle_q.size() == 0)
            $display("tb_great_circle_distance_core: clean");
        else
            $display("tb_great_circle_distance_core: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gcd_pkg.sv
rtl/gcd_prep.sv
rtl/gcd_sincos.sv
rtl/gcd_sqrt.sv
rtl/gcd_vec.sv
rtl/great_circle_distance_core.sv
test/tb_great_circle_distance_core.sv
